@@ hw/rtl/mpcs_pkg.sv @@
// Shared widths, register indexes and transaction types of the count splitter.
// Used by every module of the block; depends on nothing.
`default_nettype none
package mpcs_pkg;

    localparam int MAX_CLASSES_DEF = 6;
    localparam int READS_W         = 24;
    localparam int MASK_W          = 6;
    localparam int WEIGHT_W        = 16;
    localparam int CLS_W           = 3;
    localparam int SUM_W           = WEIGHT_W + 3;
    localparam int FRAC_W          = 8;
    localparam int PROD_W          = READS_W + WEIGHT_W;
    localparam int DIVIDEND_W      = PROD_W + FRAC_W;
    localparam int SHARE_W         = 32;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 3'd6;

    typedef struct packed {
        logic [READS_W-1:0] reads;
        logic [MASK_W-1:0]  mask;
        logic [SUM_W-1:0]   wsum;
        logic [CLS_W-1:0]   mapped;
        logic [CLS_W-1:0]   used;
        logic               gend;
    } entry_t;

    typedef struct packed {
        logic [CLS_W-1:0] cls;
        logic             last;
        logic             gend;
    } tag_t;

endpackage
`default_nettype wire

@@ hw/rtl/mpcs_queue.sv @@
// Short queue of classified exon transactions between the front and back parts.
// Depends on mpcs_pkg for the entry type and the queue depth.
`default_nettype none
module mpcs_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire mpcs_pkg::entry_t push_entry,
    input  wire logic            pop,
    output logic                 full,
    output logic                 head_valid,
    output mpcs_pkg::entry_t     head_entry
);
    import mpcs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/mpcs_front.sv @@
// Front part: accepts exon transactions and classifies them (masked weight sum,
// mapped class count). Depends on mpcs_pkg; feeds mpcs_queue.
`default_nettype none
module mpcs_front #(
    parameter int MAX_CLASSES = mpcs_pkg::MAX_CLASSES_DEF
) (
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [mpcs_pkg::READS_W-1:0]      s_exon_reads,
    input  wire logic [mpcs_pkg::MASK_W-1:0]       s_class_mask,
    input  wire logic                              s_gene_end,
    input  wire logic [mpcs_pkg::WEIGHT_W-1:0]     weight [MAX_CLASSES],
    input  wire logic [mpcs_pkg::CLS_W-1:0]        used,
    input  wire logic                              queue_full,
    output logic                                   push,
    output mpcs_pkg::entry_t                       push_entry
);
    import mpcs_pkg::*;

    logic [MASK_W-1:0] eff_mask;
    logic [SUM_W-1:0]  wsum;

    assign s_ready = !queue_full;
    assign push    = s_valid && !queue_full;

    always_comb begin
        for (int i = 0; i < MASK_W; i++) begin
            eff_mask[i] = s_class_mask[i] && (CLS_W'(i) < used);
        end
        wsum = '0;
        for (int i = 0; i < MAX_CLASSES; i++) begin
            if (eff_mask[i]) begin
                wsum = wsum + SUM_W'(weight[i]);
            end
        end
        push_entry.reads  = s_exon_reads;
        push_entry.mask   = eff_mask;
        push_entry.wsum   = wsum;
        push_entry.mapped = CLS_W'($countones(eff_mask));
        push_entry.used   = used;
        push_entry.gend   = s_gene_end;
    end

endmodule
`default_nettype wire

@@ hw/rtl/mpcs_back.sv @@
// Back part: walks the queued exon's classes, one per cycle unless stalled, and
// forms each share's dividend and divisor. Depends on mpcs_pkg; feeds mpcs_div.
`default_nettype none
module mpcs_back #(
    parameter int MAX_CLASSES = mpcs_pkg::MAX_CLASSES_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              advance,
    input  wire logic                              head_valid,
    input  wire mpcs_pkg::entry_t                  head_entry,
    input  wire logic [mpcs_pkg::WEIGHT_W-1:0]     weight [MAX_CLASSES],
    output logic                                   pop,
    output logic                                   div_valid,
    output logic [mpcs_pkg::DIVIDEND_W-1:0]        div_dividend,
    output logic [mpcs_pkg::SUM_W-1:0]             div_divisor,
    output mpcs_pkg::tag_t                         div_tag
);
    import mpcs_pkg::*;

    logic [CLS_W-1:0]    k_reg;
    logic                issue, last, zero_sum;
    logic                a_valid_reg, a_on_reg;
    logic [READS_W-1:0]  a_reads_reg;
    logic [WEIGHT_W-1:0] a_wop_reg;
    logic [SUM_W-1:0]    a_div_reg;
    tag_t                a_tag_reg;
    logic                b_valid_reg;
    logic [DIVIDEND_W-1:0] b_dividend_reg;
    logic [SUM_W-1:0]    b_div_reg;
    tag_t                b_tag_reg;
    logic [PROD_W-1:0]   product;

    assign zero_sum = (head_entry.wsum == '0);
    assign last     = (k_reg == head_entry.used - 1'b1);
    assign issue    = head_valid && advance;
    assign pop      = issue && last;
    assign product  = a_reads_reg * a_wop_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg       <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (advance) begin
            a_valid_reg <= issue;
            b_valid_reg <= a_valid_reg;
            if (issue) begin
                k_reg <= last ? '0 : k_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            a_reads_reg   <= head_entry.reads;
            a_on_reg      <= head_entry.mask[k_reg];
            a_wop_reg     <= zero_sum ? WEIGHT_W'(1) : weight[k_reg];
            if (!zero_sum) begin
                a_div_reg <= head_entry.wsum;
            end else if (head_entry.mapped == '0) begin
                a_div_reg <= SUM_W'(1);
            end else begin
                a_div_reg <= SUM_W'(head_entry.mapped);
            end
            a_tag_reg.cls  <= k_reg;
            a_tag_reg.last <= last;
            a_tag_reg.gend <= head_entry.gend;
            b_dividend_reg <= a_on_reg ? {product, FRAC_W'(0)} : '0;
            b_div_reg      <= a_div_reg;
            b_tag_reg      <= a_tag_reg;
        end
    end

    assign div_valid    = b_valid_reg;
    assign div_dividend = b_dividend_reg;
    assign div_divisor  = b_div_reg;
    assign div_tag      = b_tag_reg;

endmodule
`default_nettype wire

@@ hw/rtl/mpcs_div.sv @@
// Pipelined restoring divider, one quotient bit per stage; the last stage is the
// result register of the block. Depends on mpcs_pkg.
`default_nettype none
module mpcs_div (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              advance,
    input  wire logic                              in_valid,
    input  wire logic [mpcs_pkg::DIVIDEND_W-1:0]   in_dividend,
    input  wire logic [mpcs_pkg::SUM_W-1:0]        in_divisor,
    input  wire mpcs_pkg::tag_t                    in_tag,
    output logic                                   out_valid,
    output logic [mpcs_pkg::SHARE_W-1:0]           out_quotient,
    output mpcs_pkg::tag_t                         out_tag
);
    import mpcs_pkg::*;

    localparam int STAGES = SHARE_W;

    typedef struct packed {
        logic [SUM_W-1:0]   rem;
        logic [SHARE_W-1:0] word;
        logic [SUM_W-1:0]   dvs;
        tag_t               tag;
    } stage_t;

    stage_t             src        [STAGES];
    stage_t             stage_next [STAGES];
    stage_t             stage_reg  [STAGES];
    logic [STAGES-1:0]  vld_reg;

    always_comb begin
        logic [SUM_W:0] trial;
        logic [SUM_W:0] diff;
        logic           ge;
        src[0].rem  = SUM_W'(in_dividend[DIVIDEND_W-1:SHARE_W]);
        src[0].word = in_dividend[SHARE_W-1:0];
        src[0].dvs  = in_divisor;
        src[0].tag  = in_tag;
        for (int i = 1; i < STAGES; i++) begin
            src[i] = stage_reg[i-1];
        end
        for (int i = 0; i < STAGES; i++) begin
            trial = {src[i].rem, src[i].word[SHARE_W-1]};
            diff  = trial - {1'b0, src[i].dvs};
            ge    = (trial >= {1'b0, src[i].dvs});
            stage_next[i].rem  = ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
            stage_next[i].word = {src[i].word[SHARE_W-2:0], ge};
            stage_next[i].dvs  = src[i].dvs;
            stage_next[i].tag  = src[i].tag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (advance) begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int i = 0; i < STAGES; i++) begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    assign out_valid    = vld_reg[STAGES-1];
    assign out_quotient = stage_reg[STAGES-1].word;
    assign out_tag      = stage_reg[STAGES-1].tag;

endmodule
`default_nettype wire

@@ hw/rtl/masked_proportional_count_split.sv @@
// Top level of the masked proportional count splitter: configuration registers,
// front, queue, back and divider. Depends on mpcs_pkg and all mpcs_* modules.
//
//   channel   direction  handshake           payload
//   s_        in         s_valid / s_ready   s_exon_reads, s_class_mask, s_gene_end
//   m_        out        m_valid / m_ready   m_class_index, m_share, m_last_share, m_gene_done
//   cfg_      in         cfg_we              cfg_addr, cfg_wdata
//
// Each exon transaction yields one result per class in use (one to six); the back
// part issues one class per cycle while the output is not stalled. A result
// passes the queue entry, two operand stages and a 32-stage divider that retires
// one quotient bit per stage. Reset is synchronous and active low; it empties the
// queue and pipeline and restores the registers. A stalled result stops the
// pipeline, while the two-entry queue keeps taking exons until it is full.
`default_nettype none
module masked_proportional_count_split #(
    parameter int MAX_CLASSES = mpcs_pkg::MAX_CLASSES_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [mpcs_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  wire logic [mpcs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [mpcs_pkg::READS_W-1:0]       s_exon_reads,
    input  wire logic [mpcs_pkg::MASK_W-1:0]        s_class_mask,
    input  wire logic                               s_gene_end,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [mpcs_pkg::CLS_W-1:0]              m_class_index,
    output logic [mpcs_pkg::SHARE_W-1:0]            m_share,
    output logic                                    m_last_share,
    output logic                                    m_gene_done
);
    import mpcs_pkg::*;

    logic [WEIGHT_W-1:0]   weight_reg [MAX_CLASSES];
    logic [CLS_W-1:0]      active_reg;
    logic [CLS_W-1:0]      used;
    logic                  advance;
    logic                  queue_full, push, pop, head_valid;
    entry_t                push_entry, head_entry;
    logic                  div_valid;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [SUM_W-1:0]      div_divisor;
    tag_t                  div_tag, out_tag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_CLASSES; i++) begin
                weight_reg[i] <= '0;
            end
            active_reg <= CLS_W'(6);
        end else if (cfg_we) begin
            if (cfg_addr < CFG_IDX_W'(MAX_CLASSES)) begin
                weight_reg[cfg_addr] <= cfg_wdata[WEIGHT_W-1:0];
            end else if (cfg_addr == REG_ACTIVE) begin
                active_reg <= cfg_wdata[CLS_W-1:0];
            end
        end
    end

    always_comb begin
        if (active_reg == '0) begin
            used = CLS_W'(1);
        end else if (active_reg > CLS_W'(MAX_CLASSES)) begin
            used = CLS_W'(MAX_CLASSES);
        end else begin
            used = active_reg;
        end
    end

    assign advance = !m_valid || m_ready;

    mpcs_front #(.MAX_CLASSES(MAX_CLASSES)) u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_exon_reads (s_exon_reads),
        .s_class_mask (s_class_mask),
        .s_gene_end   (s_gene_end),
        .weight       (weight_reg),
        .used         (used),
        .queue_full   (queue_full),
        .push         (push),
        .push_entry   (push_entry)
    );

    mpcs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    mpcs_back #(.MAX_CLASSES(MAX_CLASSES)) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (advance),
        .head_valid   (head_valid),
        .head_entry   (head_entry),
        .weight       (weight_reg),
        .pop          (pop),
        .div_valid    (div_valid),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_tag      (div_tag)
    );

    mpcs_div u_div (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (advance),
        .in_valid     (div_valid),
        .in_dividend  (div_dividend),
        .in_divisor   (div_divisor),
        .in_tag       (div_tag),
        .out_valid    (m_valid),
        .out_quotient (m_share),
        .out_tag      (out_tag)
    );

    assign m_class_index = out_tag.cls;
    assign m_last_share  = out_tag.last;
    assign m_gene_done   = out_tag.gend;

endmodule
`default_nettype wire
